[src/kiva_pkg.sv]
package kiva_pkg;

    localparam int MAX_REFS   = 4096;
    localparam int MAX_DIMS   = 8;
    localparam int NEIGHBOURS = 3;

    localparam int COORD_W  = 16;
    localparam int TARGET_W = 32;
    localparam int VALUE_W  = 32;
    localparam int DIMS_W   = 4;

    localparam int REF_IDX_W    = $clog2(MAX_REFS);
    localparam int REF_CNT_W    = $clog2(MAX_REFS + 1);
    localparam int DIM_IDX_W    = $clog2(MAX_DIMS);
    localparam int COORD_DEPTH  = MAX_REFS * MAX_DIMS;
    localparam int COORD_ADDR_W = $clog2(COORD_DEPTH);

    // squared distance, exact
    localparam int SQ_W   = 2 * COORD_W;
    localparam int DIST_W = SQ_W + $clog2(MAX_DIMS);

    // root of (dist << 16)
    localparam int ROOT_SHIFT = 16;
    localparam int ROOT_W     = (DIST_W + ROOT_SHIFT + 1) / 2;
    localparam int RADIC_W    = 2 * ROOT_W;

    // weight = min(2^40 / root, 2^28 - 1)
    localparam int WEIGHT_NUM_LOG = 40;
    localparam int WEIGHT_W       = 28;
    localparam logic [WEIGHT_W-1:0] WEIGHT_SAT = {WEIGHT_W{1'b1}};
    localparam int SAT_ROOT_LIMIT = 2 ** (WEIGHT_NUM_LOG - WEIGHT_W);

    localparam int PROD_W = WEIGHT_W + 1 + TARGET_W;
    localparam int YSUM_W = 64;

    localparam int DIV_N_W   = 64;
    localparam int DIV_D_W   = 32;
    localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

    localparam int NB_IDX_W = $clog2(NEIGHBOURS);
    localparam int NB_CNT_W = $clog2(NEIGHBOURS + 1);

    localparam logic [DIMS_W-1:0] DIMS_RESET = DIMS_W'(MAX_DIMS);

    typedef enum logic [1:0] {
        OP_REF   = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_ROOT_GO,
        S_ROOT_WAIT,
        S_WDIV_GO,
        S_WDIV_WAIT,
        S_MUL,
        S_ACC,
        S_FDIV_GO,
        S_FDIV_WAIT,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [DIST_W-1:0]    dist_sq;
        logic [REF_IDX_W-1:0] idx;
    } cand_t;

    function automatic logic [DIMS_W-1:0] eff_dims(input logic [DIMS_W-1:0] d);
        logic [DIMS_W-1:0] r;
        begin
            r = d;
            if (d == '0)
            begin
                r = DIMS_W'(1);
            end
            else if (d > DIMS_W'(MAX_DIMS))
            begin
                r = DIMS_W'(MAX_DIMS);
            end
            return r;
        end
    endfunction

endpackage

[src/kiva_ram.sv]
module kiva_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/kiva_isqrt.sv]
module kiva_isqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [kiva_pkg::RADIC_W-1:0]  radicand,
    output logic                          done,
    output logic [kiva_pkg::ROOT_W-1:0]   root
);
    import kiva_pkg::*;

    // one result bit per cycle; bit_reg walks down two places a step
    logic [RADIC_W-1:0] rem_reg, rem_next;
    logic [RADIC_W-1:0] res_reg, res_next;
    logic [RADIC_W-1:0] bit_reg, bit_next;
    logic [RADIC_W-1:0] trial;

    always_comb
    begin
        rem_next = rem_reg;
        res_next = res_reg;
        bit_next = bit_reg;
        trial    = res_reg + bit_reg;
        if (start)
        begin
            rem_next = radicand;
            res_next = '0;
            bit_next = RADIC_W'(1) << (RADIC_W - 2);
        end
        else if (bit_reg != '0)
        begin
            if (rem_reg >= trial)
            begin
                rem_next = rem_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_reg <= '0;
        end
        else
        begin
            bit_reg <= bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        res_reg <= res_next;
    end

    assign done = (bit_reg == '0);
    assign root = res_reg[ROOT_W-1:0];

endmodule

[src/kiva_div.sv]
module kiva_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [kiva_pkg::DIV_N_W-1:0]  dividend,
    input  logic [kiva_pkg::DIV_D_W-1:0]  divisor,
    output logic                          done,
    output logic [kiva_pkg::DIV_N_W-1:0]  quotient
);
    import kiva_pkg::*;

    // restoring division, one quotient bit per cycle
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_N_W-1:0]   quo_reg, quo_next;
    logic [DIV_D_W-1:0]   rem_reg, rem_next;
    logic [DIV_D_W-1:0]   dvs_reg, dvs_next;
    logic [DIV_D_W:0]     shifted;
    logic                 fits;

    always_comb
    begin
        cnt_next = cnt_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        shifted  = {rem_reg, quo_reg[DIV_N_W-1]};
        fits     = (shifted >= {1'b0, dvs_reg});
        if (start)
        begin
            cnt_next = DIV_CNT_W'(DIV_N_W);
            quo_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            if (fits)
            begin
                rem_next = DIV_D_W'(shifted - {1'b0, dvs_reg});
            end
            else
            begin
                rem_next = shifted[DIV_D_W-1:0];
            end
            quo_next = {quo_reg[DIV_N_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = (cnt_reg == '0);
    assign quotient = quo_reg;

endmodule

[src/knn_idw_value_assign_core.sv]
// Channel   Handshake                 Payload
// -------   -----------------------   ----------------------------------------------
// in        in_valid / in_stall       opcode[1:0], coord[15:0] s, target[31:0] s
// out       out_valid / out_stall     assigned_value[31:0] s, no_reference, refs_dropped
// cfg       cfg_we (no wait)          cfg_wdata[3:0] -> dims_in_use
//
// Reference, clear and non-final query transfers never stall intake.
// A query's last coordinate starts a scan of the coordinate RAM, one word per
// cycle, then per neighbour a square root, a weight division (skipped when the
// weight saturates) and a multiply and add, then the final division.
// Reset clears the state, counters and flags and sets dims_in_use to eight;
// the RAMs need no clearing.
// in_stall is high while a query is being worked; a held result does not block
// intake of further transfers until the next result is ready.
module knn_idw_value_assign_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     opcode,
    input  logic signed [15:0]             coord,
    input  logic signed [31:0]             target,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [31:0]             assigned_value,
    output logic                           no_reference,
    output logic                           refs_dropped,
    input  logic                           cfg_we,
    input  logic [3:0]                     cfg_wdata
);
    import kiva_pkg::*;

    // ---------------- control state ----------------
    state_t                 state_reg, state_next;
    logic [DIMS_W-1:0]      dims_reg;
    logic [DIM_IDX_W-1:0]   pos_reg, pos_next;
    logic [REF_CNT_W-1:0]   count_reg, count_next;
    logic                   ovf_reg, ovf_next;
    logic [REF_IDX_W-1:0]   scan_ref_reg, scan_ref_next;
    logic [DIM_IDX_W-1:0]   scan_dim_reg, scan_dim_next;
    logic [NB_CNT_W-1:0]    filled_reg, filled_next;
    logic [NB_IDX_W-1:0]    n_reg, n_next;
    logic                   s1_valid_reg, s2_valid_reg;
    logic                   out_valid_reg, out_valid_next;

    // ---------------- payload ----------------
    logic signed [COORD_W-1:0] query_reg [MAX_DIMS];
    logic [DIM_IDX_W-1:0]   s1_dim_reg;
    logic                   s1_first_reg, s1_last_reg, s2_first_reg, s2_last_reg;
    logic [REF_IDX_W-1:0]   s1_ref_reg, s2_ref_reg;
    logic [SQ_W-1:0]        sq_reg, sq_next;
    logic [DIST_W-1:0]      acc_reg, acc_next;
    cand_t                  best_reg [NEIGHBOURS];
    cand_t                  best_next [NEIGHBOURS];
    logic [WEIGHT_W-1:0]    w_reg, w_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic [YSUM_W-1:0]      ysum_reg, ysum_next;
    logic [DIV_D_W-1:0]     wsum_reg, wsum_next;
    logic [VALUE_W-1:0]     res_value_reg, res_value_next;
    logic                   res_noref_reg, res_noref_next;
    logic                   res_drop_reg, res_drop_next;
    logic [VALUE_W-1:0]     out_value_reg, out_value_next;
    logic                   out_noref_reg, out_noref_next;
    logic                   out_drop_reg, out_drop_next;

    // ---------------- item decode ----------------
    logic [DIMS_W-1:0]      eff;
    logic [DIM_IDX_W-1:0]   pos_use;
    logic                   last_coord;
    logic                   room;
    logic                   accept;
    logic                   coord_we;
    logic                   target_we;
    logic [COORD_ADDR_W-1:0] coord_waddr, coord_raddr;
    logic [COORD_W-1:0]     coord_rdata;
    logic [TARGET_W-1:0]    target_rdata;

    assign eff        = eff_dims(dims_reg);
    assign accept     = in_valid && !in_stall;
    assign room       = (count_reg < REF_CNT_W'(MAX_REFS));
    assign in_stall   = (state_reg != S_IDLE);

    always_comb
    begin
        if (DIMS_W'(pos_reg) >= eff)
        begin
            pos_use = DIM_IDX_W'(eff - 1'b1);
        end
        else
        begin
            pos_use = pos_reg;
        end
        last_coord = ((DIMS_W'(pos_use) + 1'b1) >= eff);
    end

    assign coord_we    = accept && (opcode == OP_REF) && room;
    assign target_we   = coord_we && last_coord;
    assign coord_waddr = COORD_ADDR_W'(count_reg[REF_IDX_W-1:0]) * COORD_ADDR_W'(MAX_DIMS)
                         + COORD_ADDR_W'(pos_use);
    assign coord_raddr = COORD_ADDR_W'(scan_ref_reg) * COORD_ADDR_W'(MAX_DIMS)
                         + COORD_ADDR_W'(scan_dim_reg);

    kiva_ram #(
        .WIDTH (COORD_W),
        .DEPTH (COORD_DEPTH)
    ) u_coord_ram (
        .clk   (clk),
        .we    (coord_we),
        .waddr (coord_waddr),
        .wdata (coord),
        .raddr (coord_raddr),
        .rdata (coord_rdata)
    );

    kiva_ram #(
        .WIDTH (TARGET_W),
        .DEPTH (MAX_REFS)
    ) u_target_ram (
        .clk   (clk),
        .we    (target_we),
        .waddr (count_reg[REF_IDX_W-1:0]),
        .wdata (target),
        .raddr (best_reg[n_reg].idx),
        .rdata (target_rdata)
    );

    // ---------------- shared arithmetic units ----------------
    logic                   sqrt_start, sqrt_done;
    logic [RADIC_W-1:0]     sqrt_in;
    logic [ROOT_W-1:0]      root;
    logic                   div_start, div_done;
    logic [DIV_N_W-1:0]     div_dividend, div_quot;
    logic [DIV_D_W-1:0]     div_divisor;

    assign sqrt_in = RADIC_W'(best_reg[n_reg].dist_sq) << ROOT_SHIFT;

    kiva_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sqrt_in),
        .done     (sqrt_done),
        .root     (root)
    );

    kiva_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    // ---------------- distance pipeline ----------------
    // stage 1: RAM word back, square the difference
    // stage 2: accumulate; on a point's last coordinate, insert into the top list
    logic signed [COORD_W:0]     diff;
    logic signed [2*COORD_W+1:0] sq_full;
    logic [DIST_W-1:0]           dist_sum;
    logic [NB_CNT_W-1:0]         ins_pos;

    always_comb
    begin
        diff     = $signed({query_reg[s1_dim_reg][COORD_W-1], query_reg[s1_dim_reg]})
                   - $signed({coord_rdata[COORD_W-1], coord_rdata});
        sq_full  = diff * diff;
        sq_next  = sq_full[SQ_W-1:0];
        dist_sum = (s2_first_reg ? '0 : acc_reg) + DIST_W'(sq_reg);
        acc_next = s2_valid_reg ? dist_sum : acc_reg;

        // entries already held at equal distance stay ahead
        ins_pos = '0;
        for (int i = 0; i < NEIGHBOURS; i++)
        begin
            if ((NB_CNT_W'(i) < filled_reg) && (best_reg[i].dist_sq <= dist_sum))
            begin
                ins_pos = ins_pos + 1'b1;
            end
        end
        for (int i = 0; i < NEIGHBOURS; i++)
        begin
            best_next[i] = best_reg[i];
            if (s2_valid_reg && s2_last_reg)
            begin
                if (NB_CNT_W'(i) == ins_pos)
                begin
                    best_next[i].dist_sq = dist_sum;
                    best_next[i].idx     = s2_ref_reg;
                end
                else if ((NB_CNT_W'(i) > ins_pos) && (i > 0))
                begin
                    best_next[i] = best_reg[(i > 0) ? i - 1 : 0];
                end
            end
        end
    end

    // ---------------- final division operands ----------------
    logic                   y_neg;
    logic [YSUM_W-1:0]      y_mag;
    logic [DIV_N_W-1:0]     fdiv_dividend;
    logic [VALUE_W-1:0]     q_val;

    assign y_neg         = ysum_reg[YSUM_W-1];
    assign y_mag         = y_neg ? (YSUM_W'(0) - ysum_reg) : ysum_reg;
    assign fdiv_dividend = DIV_N_W'(y_mag) + DIV_N_W'(wsum_reg >> 1);
    assign q_val         = div_quot[VALUE_W-1:0];

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        scan_ref_next  = scan_ref_reg;
        scan_dim_next  = scan_dim_reg;
        filled_next    = filled_reg;
        n_next         = n_reg;
        w_next         = w_reg;
        prod_next      = prod_reg;
        ysum_next      = ysum_reg;
        wsum_next      = wsum_reg;
        res_value_next = res_value_reg;
        res_noref_next = res_noref_reg;
        res_drop_next  = res_drop_reg;
        out_value_next = out_value_reg;
        out_noref_next = out_noref_reg;
        out_drop_next  = out_drop_reg;
        out_valid_next = out_valid_reg && out_stall;
        sqrt_start     = 1'b0;
        div_start      = 1'b0;
        div_dividend   = fdiv_dividend;
        div_divisor    = wsum_reg;

        if (s2_valid_reg && s2_last_reg)
        begin
            if (filled_reg != NB_CNT_W'(NEIGHBOURS))
            begin
                filled_next = filled_reg + 1'b1;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (opcode_t'(opcode))
                        OP_CLEAR:
                        begin
                            count_next = '0;
                            ovf_next   = 1'b0;
                            pos_next   = '0;
                        end
                        OP_NONE:
                        begin
                        end
                        OP_REF:
                        begin
                            pos_next = last_coord ? '0 : pos_use + 1'b1;
                            if (last_coord)
                            begin
                                if (room)
                                begin
                                    count_next = count_reg + 1'b1;
                                end
                                else
                                begin
                                    ovf_next = 1'b1;
                                end
                            end
                        end
                        OP_QUERY:
                        begin
                            pos_next = last_coord ? '0 : pos_use + 1'b1;
                            if (last_coord)
                            begin
                                res_drop_next  = ovf_reg;
                                res_noref_next = 1'b0;
                                if (count_reg == '0)
                                begin
                                    res_value_next = '0;
                                    res_noref_next = 1'b1;
                                    state_next     = S_OUT;
                                end
                                else
                                begin
                                    scan_ref_next = '0;
                                    scan_dim_next = '0;
                                    filled_next   = '0;
                                    state_next    = S_SCAN;
                                end
                            end
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (DIMS_W'(scan_dim_reg) + 1'b1 >= eff)
                begin
                    scan_dim_next = '0;
                    if (REF_CNT_W'(scan_ref_reg) + 1'b1 >= count_reg)
                    begin
                        state_next = S_DRAIN;
                    end
                    else
                    begin
                        scan_ref_next = scan_ref_reg + 1'b1;
                    end
                end
                else
                begin
                    scan_dim_next = scan_dim_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                if (!s1_valid_reg && !s2_valid_reg)
                begin
                    n_next     = '0;
                    ysum_next  = '0;
                    wsum_next  = '0;
                    state_next = S_ROOT_GO;
                end
            end
            S_ROOT_GO:
            begin
                sqrt_start = 1'b1;
                state_next = S_ROOT_WAIT;
            end
            S_ROOT_WAIT:
            begin
                if (sqrt_done)
                begin
                    // small roots (zero included) saturate the weight
                    if (root <= ROOT_W'(SAT_ROOT_LIMIT))
                    begin
                        w_next     = WEIGHT_SAT;
                        state_next = S_MUL;
                    end
                    else
                    begin
                        state_next = S_WDIV_GO;
                    end
                end
            end
            S_WDIV_GO:
            begin
                div_start    = 1'b1;
                div_dividend = DIV_N_W'(1) << WEIGHT_NUM_LOG;
                div_divisor  = DIV_D_W'(root);
                state_next   = S_WDIV_WAIT;
            end
            S_WDIV_WAIT:
            begin
                if (div_done)
                begin
                    w_next     = div_quot[WEIGHT_W-1:0];
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                prod_next  = $signed({1'b0, w_reg}) * $signed(target_rdata);
                state_next = S_ACC;
            end
            S_ACC:
            begin
                ysum_next = ysum_reg + {{(YSUM_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
                wsum_next = wsum_reg + DIV_D_W'(w_reg);
                if (NB_CNT_W'(n_reg) + 1'b1 >= filled_reg)
                begin
                    state_next = S_FDIV_GO;
                end
                else
                begin
                    n_next     = n_reg + 1'b1;
                    state_next = S_ROOT_GO;
                end
            end
            S_FDIV_GO:
            begin
                div_start  = 1'b1;
                state_next = S_FDIV_WAIT;
            end
            S_FDIV_WAIT:
            begin
                if (div_done)
                begin
                    res_value_next = y_neg ? (VALUE_W'(0) - q_val) : q_val;
                    state_next     = S_OUT;
                end
            end
            S_OUT:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = res_value_reg;
                    out_noref_next = res_noref_reg;
                    out_drop_next  = res_drop_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            dims_reg      <= DIMS_RESET;
            pos_reg       <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            scan_ref_reg  <= '0;
            scan_dim_reg  <= '0;
            filled_reg    <= '0;
            n_reg         <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_we)
            begin
                dims_reg <= cfg_wdata;
            end
            pos_reg       <= pos_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            scan_ref_reg  <= scan_ref_next;
            scan_dim_reg  <= scan_dim_next;
            filled_reg    <= filled_next;
            n_reg         <= n_next;
            s1_valid_reg  <= (state_reg == S_SCAN);
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (opcode == OP_QUERY))
        begin
            query_reg[pos_use] <= coord;
        end
        s1_dim_reg    <= scan_dim_reg;
        s1_first_reg  <= (scan_dim_reg == '0);
        s1_last_reg   <= (DIMS_W'(scan_dim_reg) + 1'b1 >= eff);
        s1_ref_reg    <= scan_ref_reg;
        s2_first_reg  <= s1_first_reg;
        s2_last_reg   <= s1_last_reg;
        s2_ref_reg    <= s1_ref_reg;
        sq_reg        <= sq_next;
        acc_reg       <= acc_next;
        for (int i = 0; i < NEIGHBOURS; i++)
        begin
            best_reg[i] <= best_next[i];
        end
        w_reg         <= w_next;
        prod_reg      <= prod_next;
        ysum_reg      <= ysum_next;
        wsum_reg      <= wsum_next;
        res_value_reg <= res_value_next;
        res_noref_reg <= res_noref_next;
        res_drop_reg  <= res_drop_next;
        out_value_reg <= out_value_next;
        out_noref_reg <= out_noref_next;
        out_drop_reg  <= out_drop_next;
    end

    assign out_valid      = out_valid_reg;
    assign assigned_value = $signed(out_value_reg);
    assign no_reference   = out_noref_reg;
    assign refs_dropped   = out_drop_reg;

endmodule

[src/kiva_checker.sv]
module kiva_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic [1:0]         opcode,
    input logic signed [15:0] coord,
    input logic signed [31:0] target,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [31:0] assigned_value,
    input logic               no_reference,
    input logic               refs_dropped,
    input logic               cfg_we,
    input logic [3:0]         cfg_wdata
);
    import kiva_pkg::*;

    // a held result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(assigned_value)
            && $stable(no_reference) && $stable(refs_dropped))
        else $error("result changed while stalled");

    a_noref_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && no_reference |-> assigned_value == 32'sd0)
        else $error("empty reference set with nonzero value");

    // only query completion ever stalls intake
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall
            && (opcode == OP_REF || opcode == OP_CLEAR || opcode == OP_NONE)
        |=> !in_stall)
        else $error("stall after a non-query transfer");

    // a new result appears only out of the busy phase
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without a query in progress");

endmodule

bind knn_idw_value_assign_core kiva_checker u_kiva_checker (.*);

[test/knn_idw_value_assign_core_test.sv]
`timescale 1ns / 1ps

module knn_idw_value_assign_core_test;

    import kiva_pkg::*;

    // weight ceiling, stands in for the epsilon of 1/(sqrt(d)+eps)
    localparam longint unsigned WEIGHT_CAP = 64'h0FFF_FFFF;
    // cycles with no transfer on either channel before the run is declared hung;
    // worst case is a full-capacity scan at one dimension plus three weights
    localparam int QUIET_LIMIT = 100000;
    // settle time after the last result; refs and clears never stall intake
    localparam int SETTLE_CYCLES = 20;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         opcode;
    logic signed [15:0] coord;
    logic signed [31:0] target;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] assigned_value;
    logic               no_reference;
    logic               refs_dropped;
    logic               cfg_we;
    logic [3:0]         cfg_wdata;

    knn_idw_value_assign_core DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .coord          (coord),
        .target         (target),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .assigned_value (assigned_value),
        .no_reference   (no_reference),
        .refs_dropped   (refs_dropped),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata)
    );

    typedef struct {
        logic signed [31:0] value;
        logic               no_ref;
        logic               dropped;
    } assignment_t;

    // ------------------------------------------------------------------
    // Shadow of the block: reference store, query buffer, counters.
    // Written-bit maps track which store entries hold real data, so the
    // stimulus never makes the block read a location nobody wrote.
    // ------------------------------------------------------------------
    logic signed [15:0] shadow_ref_xy [MAX_REFS*MAX_DIMS];
    bit                 ref_xy_written [MAX_REFS*MAX_DIMS];
    logic signed [31:0] shadow_ref_tgt [MAX_REFS];
    logic signed [15:0] shadow_query_xy [MAX_DIMS];
    bit                 query_written [MAX_DIMS];
    int                 stored_refs;
    int                 point_pos;
    int                 shortest_prefix;   // min written leading coords over stored refs
    bit                 overflowed;
    logic [3:0]         dims_reg;

    assignment_t        expected_assignments [$];

    int                 errors;
    int                 sender_idle_pct;
    int                 receiver_stall_pct;
    int                 hold_left;          // receiver hold-off, counted down per cycle

    // ------------------------------------------------------------------
    // Report: one line per mismatch, counted
    // ------------------------------------------------------------------
    task automatic report(input string what, input longint got, input longint want);
        begin
            $display("MISMATCH %s: got %0d expected %0d", what, got, want);
            errors++;
        end
    endtask

    function automatic int active_dims();
        int d;
        begin
            d = dims_reg;
            if (d == 0)
            begin
                d = 1;
            end
            if (d > MAX_DIMS)
            begin
                d = MAX_DIMS;
            end
            return d;
        end
    endfunction

    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        begin
            r = 0;
            b = 64'd1 << 62;
            while (b > v)
            begin
                b = b >> 2;
            end
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else
                begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        end
    endfunction

    // Nearest three by squared distance, earlier ref wins a tie, then the
    // saturated inverse-root weighted mean, rounded half away from zero.
    function automatic logic signed [31:0] weighted_neighbour_mean(input int d);
        longint unsigned near_dist [NEIGHBOURS];
        int              near_idx  [NEIGHBOURS];
        int              filled;
        int              slot;
        longint unsigned dist_sq;
        longint          diff;
        longint unsigned root;
        longint unsigned w;
        longint unsigned w_sum;
        longint          y_sum;
        longint unsigned mag;
        longint unsigned q;
        begin
            filled = 0;
            w_sum  = 0;
            y_sum  = 0;
            for (int j = 0; j < stored_refs; j++)
            begin
                dist_sq = 0;
                for (int p = 0; p < d; p++)
                begin
                    diff = longint'(shadow_query_xy[p]) - longint'(shadow_ref_xy[j*MAX_DIMS+p]);
                    dist_sq += longint'(diff * diff);
                end
                // first slot holding a strictly larger distance
                slot = filled;
                for (int i = filled - 1; i >= 0; i--)
                begin
                    if (dist_sq < near_dist[i])
                    begin
                        slot = i;
                    end
                end
                if (slot < NEIGHBOURS)
                begin
                    for (int i = NEIGHBOURS - 1; i > slot; i--)
                    begin
                        near_dist[i] = near_dist[i-1];
                        near_idx[i]  = near_idx[i-1];
                    end
                    near_dist[slot] = dist_sq;
                    near_idx[slot]  = j;
                    if (filled < NEIGHBOURS)
                    begin
                        filled++;
                    end
                end
            end
            for (int i = 0; i < filled; i++)
            begin
                root = floor_sqrt(near_dist[i] << 16);
                w = (root == 0) ? WEIGHT_CAP : ((64'd1 << 40) / root);
                if (w > WEIGHT_CAP)
                begin
                    w = WEIGHT_CAP;
                end
                w_sum += w;
                y_sum += longint'(w) * longint'(shadow_ref_tgt[near_idx[i]]);
            end
            if (w_sum == 0)
            begin
                return '0;
            end
            mag = (y_sum < 0) ? -y_sum : y_sum;
            q = (mag + w_sum / 2) / w_sum;
            return (y_sum < 0) ? -$signed(q[31:0]) : $signed(q[31:0]);
        end
    endfunction

    // A query that would read an unwritten query slot or ref coordinate is
    // turned into a ref coordinate instead.
    function automatic opcode_t safe_opcode(input opcode_t op);
        int d;
        int p;
        bit ok;
        begin
            if (op != OP_QUERY)
            begin
                return op;
            end
            d = active_dims();
            p = (point_pos >= d) ? d - 1 : point_pos;
            if (p + 1 < d)
            begin
                return op;
            end
            ok = (stored_refs == 0) || (shortest_prefix >= d);
            for (int i = 0; i < d; i++)
            begin
                if (i != p && !query_written[i])
                begin
                    ok = 0;
                end
            end
            return ok ? op : OP_REF;
        end
    endfunction

    // Update the shadow for one accepted transfer, queue the result if any
    task automatic absorb_transfer(input opcode_t op, input logic signed [15:0] c,
                                   input logic signed [31:0] t);
        int d;
        int p;
        int prefix;
        bit last;
        assignment_t a;
        begin
            if (op == OP_CLEAR)
            begin
                stored_refs     = 0;
                overflowed      = 0;
                point_pos       = 0;
                shortest_prefix = MAX_DIMS;
            end
            else if (op != OP_NONE)
            begin
                d = active_dims();
                p = (point_pos >= d) ? d - 1 : point_pos;
                last = (p + 1 >= d);
                point_pos = last ? 0 : p + 1;
                if (op == OP_REF)
                begin
                    if (stored_refs < MAX_REFS)
                    begin
                        shadow_ref_xy[stored_refs*MAX_DIMS+p]  = c;
                        ref_xy_written[stored_refs*MAX_DIMS+p] = 1;
                        if (last)
                        begin
                            shadow_ref_tgt[stored_refs] = t;
                            prefix = 0;
                            while (prefix < MAX_DIMS &&
                                   ref_xy_written[stored_refs*MAX_DIMS+prefix])
                            begin
                                prefix++;
                            end
                            if (prefix < shortest_prefix)
                            begin
                                shortest_prefix = prefix;
                            end
                            stored_refs++;
                        end
                    end
                    else if (last)
                    begin
                        overflowed = 1;
                    end
                end
                else
                begin
                    shadow_query_xy[p] = c;
                    query_written[p]   = 1;
                    if (last)
                    begin
                        a.no_ref  = (stored_refs == 0);
                        a.value   = a.no_ref ? '0 : weighted_neighbour_mean(d);
                        a.dropped = overflowed;
                        expected_assignments.insert(expected_assignments.size(), a);
                    end
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sender: one transfer, with random idle cycles in front of it
    // ------------------------------------------------------------------
    task automatic send_item(input opcode_t op, input logic signed [15:0] c,
                             input logic signed [31:0] t);
        opcode_t op_sent;
        begin
            op_sent = safe_opcode(op);
            while ($urandom_range(99) < sender_idle_pct)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid <= 1'b1;
            opcode   <= op_sent;
            coord    <= c;
            target   <= t;
            @(posedge clk);
            while (in_stall)
            begin
                @(posedge clk);
            end
            absorb_transfer(op_sent, c, t);
        end
    endtask

    // Drop valid and wait until every queued result has been checked
    task automatic wait_idle();
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while (expected_assignments.size() != 0)
            begin
                @(posedge clk);
            end
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
    endtask

    task automatic write_dims(input logic [3:0] value);
        begin
            wait_idle();
            cfg_we    <= 1'b1;
            cfg_wdata <= value;
            @(posedge clk);
            cfg_we    <= 1'b0;
            dims_reg   = value;
        end
    endtask

    function automatic logic signed [15:0] pick_coord();
        case ($urandom_range(7))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return '0;
            3, 4: return 16'($signed($urandom_range(512)) - 256);   // near the origin
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [31:0] pick_target();
        case ($urandom_range(5))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            default: return 32'($urandom);
        endcase
    endfunction

    task automatic send_point(input opcode_t op, output int sent);
        int d;
        begin
            d = active_dims();
            for (int i = 0; i < d; i++)
            begin
                send_item(op, pick_coord(), pick_target());
            end
            sent = d;
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        begin
            // empty set at the reset width of eight
            for (int i = 0; i < MAX_DIMS; i++)
            begin
                send_item(OP_QUERY, (i % 2) ? 16'sh7FFF : 16'sh8000, '0);
            end
            write_dims(4'd2);
            send_item(OP_REF, 16'sh8000, '0);
            send_item(OP_REF, 16'sh8000, 32'sh7FFF_FFFF);
            send_item(OP_REF, 16'sh7FFF, '0);
            send_item(OP_REF, 16'sh7FFF, 32'sh8000_0000);
            send_item(OP_REF, 16'sh0000, '0);
            send_item(OP_REF, 16'sh0000, 32'sh0001_2345);
            // same point again: tie, the earlier one is kept
            send_item(OP_REF, 16'sh0000, '0);
            send_item(OP_REF, 16'sh0000, -32'sd5);
            // exact hit, weight saturates
            send_item(OP_QUERY, 16'sh0000, '0);
            send_item(OP_QUERY, 16'sh0000, '0);
            // farthest corner
            send_item(OP_QUERY, 16'sh7FFF, '0);
            send_item(OP_QUERY, 16'sh8000, '0);
            send_item(OP_NONE, 16'sh1234, 32'sh5555_AAAA);
            // mixed point: ref coordinate first, query completes it
            send_item(OP_REF, 16'sd100, '0);
            send_item(OP_QUERY, -16'sd100, '0);
            send_item(OP_CLEAR, '0, '0);
            send_item(OP_QUERY, 16'sd3, '0);
            send_item(OP_QUERY, 16'sd4, '0);
            // partial point, then the width shrinks below the position
            send_item(OP_REF, 16'sd7, '0);
            write_dims(4'd0);
            send_item(OP_REF, 16'sd9, 32'sd65536);
            send_item(OP_QUERY, 16'sd9, '0);
            write_dims(4'd15);
            send_item(OP_CLEAR, '0, '0);
            wait_idle();
        end
    endtask

    task automatic test_capacity();
        begin
            write_dims(4'd1);
            send_item(OP_CLEAR, '0, '0);
            for (int i = 0; i < MAX_REFS + 4; i++)
            begin
                send_item(OP_REF, pick_coord(), pick_target());
            end
            send_item(OP_QUERY, pick_coord(), '0);
            send_item(OP_QUERY, 16'sh7FFF, '0);
            send_item(OP_CLEAR, '0, '0);
            send_item(OP_QUERY, 16'sh8000, '0);
            wait_idle();
        end
    endtask

    task automatic random_items(input int count);
        int sent;
        int n;
        int r;
        begin
            sent = 0;
            while (sent < count)
            begin
                r = $urandom_range(99);
                if (r < 55)
                begin
                    send_point(OP_REF, n);
                end
                else if (r < 85)
                begin
                    send_point(OP_QUERY, n);
                end
                else if (r < 89)
                begin
                    send_item(OP_CLEAR, pick_coord(), pick_target());
                    n = 1;
                end
                else if (r < 92)
                begin
                    send_item(OP_NONE, pick_coord(), pick_target());
                    n = 0;
                end
                else
                begin
                    // broken point: random kind per coordinate
                    n = $urandom_range(active_dims(), 1);
                    for (int i = 0; i < n; i++)
                    begin
                        send_item($urandom_range(1) ? OP_QUERY : OP_REF,
                                  pick_coord(), pick_target());
                    end
                end
                sent += n;
            end
        end
    endtask

    task automatic test_random_phases();
        logic [3:0] widths [5];
        int idle_mode [4][2];
        begin
            widths    = '{4'd8, 4'd1, 4'd15, 4'd0, 4'($urandom_range(7, 2))};
            idle_mode = '{'{0, 0}, '{58, 0}, '{0, 58}, '{24, 24}};
            for (int ph = 0; ph < 5; ph++)
            begin
                write_dims(widths[ph]);
                sender_idle_pct    = idle_mode[ph % 4][0];
                receiver_stall_pct = idle_mode[ph % 4][1];
                random_items(150);
            end
            wait_idle();
        end
    endtask

    // Receiver holds off for a long stretch while queries keep coming,
    // then the sender waits for everything to drain.
    task automatic test_backpressure();
        int n;
        begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 0;
            write_dims(4'd2);
            send_item(OP_CLEAR, '0, '0);
            for (int i = 0; i < 5; i++)
            begin
                send_point(OP_REF, n);
            end
            hold_left = 400;
            for (int i = 0; i < 20; i++)
            begin
                send_point(OP_QUERY, n);
            end
            wait_idle();
        end
    endtask

    // ------------------------------------------------------------------
    // Clock, reset, result checker, watchdog
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                if (expected_assignments.size() == 0)
                begin
                    report("result with nothing pending, value", assigned_value, 0);
                end
                else
                begin
                    assignment_t e;
                    e = expected_assignments.pop_front();
                    if (assigned_value !== e.value)
                    begin
                        report("assigned_value", assigned_value, e.value);
                    end
                    if (no_reference !== e.no_ref)
                    begin
                        report("no_reference", no_reference, e.no_ref);
                    end
                    if (refs_dropped !== e.dropped)
                    begin
                        report("refs_dropped", refs_dropped, e.dropped);
                    end
                end
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < receiver_stall_pct);
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
            if (quiet >= QUIET_LIMIT)
            begin
                $display("knn_idw_value_assign_core_test NOT OK");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        opcode    <= OP_NONE;
        coord     <= '0;
        target    <= '0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        errors             = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_left          = 0;
        stored_refs        = 0;
        point_pos          = 0;
        shortest_prefix    = MAX_DIMS;
        overflowed         = 0;
        dims_reg           = 4'd8;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_capacity();
        test_random_phases();
        test_backpressure();
        wait_idle();

        if (errors == 0 && expected_assignments.size() == 0)
        begin
            $display("knn_idw_value_assign_core_test OK");
        end
        else
        begin
            if (expected_assignments.size() != 0)
            begin
                report("results never arrived", expected_assignments.size(), 0);
            end
            $display("knn_idw_value_assign_core_test NOT OK");
        end
        $finish;
    end

endmodule
